>>> rtl/heading_aligned_box_corners_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading-aligned box corner core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HEADING_ALIGNED_BOX_CORNERS_CORE_MACROS_SVH
`define HEADING_ALIGNED_BOX_CORNERS_CORE_MACROS_SVH

// Overlapping implication, checked while reset is low.
`define HABC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent, while reset is low.
`define HABC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/habc_pkg.sv
// ----------------------------------------------------------------------------
// habc_pkg
// Types and constants shared by the box corner core and its CORDIC pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package habc_pkg;

   // Width of the vectoring datapath and of the rotation datapath.
   localparam int VecWidth = 36;
   localparam int RotWidth = 34;
   // Fraction bits of the trigonometric values inside the CORDIC.
   localparam int TrigFrac = 30;
   // 1/K in Q4.30.
   localparam logic signed [RotWidth-1:0] InvGain = 34'sh026DD3B6A;

   localparam int CfgCount = 4;
   typedef enum logic [1:0] {
      REG_FRONT = 2'd0,
      REG_REAR  = 2'd1,
      REG_RIGHT = 2'd2,
      REG_LEFT  = 2'd3
   } reg_index_type;

   // Fields that ride alongside the heading computation.
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] ef;
      logic signed [31:0] er;
      logic signed [31:0] eg;
      logic signed [31:0] el;
      logic               zero;
      logic               flip;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -38'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/habc_cordic.sv
// ----------------------------------------------------------------------------
// habc_cordic
// One register stage per CORDIC step. Each stage takes a vectoring step and
// replays its direction at once on the rotation vector.
// ----------------------------------------------------------------------------
`default_nettype none
module habc_cordic #(
   parameter int STEPS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  wire                                   in_valid,
   input  wire logic signed [habc_pkg::VecWidth-1:0] in_x,
   input  wire logic signed [habc_pkg::VecWidth-1:0] in_y,
   input  wire habc_pkg::side_type               in_side,
   output logic                                  out_valid,
   output logic signed [habc_pkg::RotWidth-1:0]  out_x,
   output logic signed [habc_pkg::RotWidth-1:0]  out_y,
   output habc_pkg::side_type                    out_side
);
   import habc_pkg::*;

   logic                       valid_ff [STEPS];
   logic signed [VecWidth-1:0] vx_ff    [STEPS];
   logic signed [VecWidth-1:0] vy_ff    [STEPS];
   logic signed [RotWidth-1:0] rx_ff    [STEPS];
   logic signed [RotWidth-1:0] ry_ff    [STEPS];
   side_type                   side_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                       valid_src;
      logic signed [VecWidth-1:0] vx_src, vy_src, vx_in, vy_in;
      logic signed [RotWidth-1:0] rx_src, ry_src, rx_in, ry_in;
      side_type                   side_src;
      logic                       dir;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign vx_src    = in_x;
         assign vy_src    = in_y;
         assign rx_src    = InvGain;
         assign ry_src    = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign vx_src    = vx_ff[i-1];
         assign vy_src    = vy_ff[i-1];
         assign rx_src    = rx_ff[i-1];
         assign ry_src    = ry_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         dir = ~vy_src[VecWidth-1];
         if (dir) begin
            vx_in = vx_src + (vy_src >>> i);
            vy_in = vy_src - (vx_src >>> i);
            rx_in = rx_src - (ry_src >>> i);
            ry_in = ry_src + (rx_src >>> i);
         end else begin
            vx_in = vx_src - (vy_src >>> i);
            vy_in = vy_src + (vx_src >>> i);
            rx_in = rx_src + (ry_src >>> i);
            ry_in = ry_src - (rx_src >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[i]   <= vx_in;
            vy_ff[i]   <= vy_in;
            rx_ff[i]   <= rx_in;
            ry_ff[i]   <= ry_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_x     = rx_ff[STEPS-1];
   assign out_y     = ry_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/heading_aligned_box_corners_core.sv
// ----------------------------------------------------------------------------
// heading_aligned_box_corners_core
// A request word passes the stage 0 to 2 registers, the CORDIC stages and the
// trig, multiply, rounding and sum registers to the output register, which
// sends its four corner words on the single response channel as each is taken.
// A new request waits while the sum stage is full and the output is still busy.
// Reset clears the extent registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module heading_aligned_box_corners_core #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  wire          clock,
   input  wire          reset,
   // center_x[31:0], center_y[63:32], vel_x[95:64], vel_y[127:96],
   // radius[158:128], zero pad [159]
   input  wire  [159:0] req_tdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // corner_x[31:0], corner_y[63:32]
   output logic [63:0]  rsp_tdata,
   // corner_index[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [7:0]   csr_index,
   input  wire  [31:0]  csr_data
);
   import habc_pkg::*;

   localparam int TW    = FRAC_BITS + 3;
   localparam int RS    = TrigFrac - FRAC_BITS;
   localparam int PW    = 32 + TW + 1;
   localparam int SW    = 38;
   localparam logic signed [RotWidth-1:0] RHALF = {{(RotWidth-1){1'b0}}, 1'b1} << (RS-1);
   localparam logic signed [PW-1:0]       PHALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS-1);
   localparam logic signed [TW-1:0]       ONE   = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic signed [31:0] cfg_ff [CfgCount];
   logic adv;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CfgCount; i++) cfg_ff[i] <= '0;
      end else if (csr_valid && csr_index < 8'(CfgCount)) begin
         cfg_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // Stage 0: extents, half-plane fold and magnitudes.
   logic signed [31:0] in_vx, in_vy;
   logic [30:0]        in_r;
   logic signed [32:0] f_vx, f_vy;
   logic               f_flip;
   side_type           s0_in;
   logic [31:0]        ax0_in, ay0_in;
   logic               yn0_in;

   function automatic logic signed [31:0] ext_sum(input logic [30:0] r,
                                                   input logic signed [31:0] e);
      logic signed [37:0] s;
      s = $signed({7'b0, r}) + 38'(e);
      return sat32(s);
   endfunction

   always_comb begin
      in_vx  = req_tdata[95:64];
      in_vy  = req_tdata[127:96];
      in_r   = req_tdata[158:128];
      f_flip = in_vx[31];
      f_vx   = f_flip ? -33'(in_vx) : 33'(in_vx);
      f_vy   = f_flip ? -33'(in_vy) : 33'(in_vy);
      yn0_in = f_vy[32];
      ax0_in = f_vx[31:0];
      ay0_in = yn0_in ? 32'(-f_vy) : f_vy[31:0];
      s0_in.cx   = req_tdata[31:0];
      s0_in.cy   = req_tdata[63:32];
      s0_in.ef   = ext_sum(in_r, cfg_ff[REG_FRONT]);
      s0_in.er   = ext_sum(in_r, cfg_ff[REG_REAR]);
      s0_in.eg   = ext_sum(in_r, cfg_ff[REG_RIGHT]);
      s0_in.el   = ext_sum(in_r, cfg_ff[REG_LEFT]);
      s0_in.zero = (in_vx == 32'sd0) && (in_vy == 32'sd0);
      s0_in.flip = f_flip;
   end

   logic        v0_ff, v1_ff, v2_ff;
   side_type    s0_ff, s1_ff, s2_ff;
   logic [31:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff;
   logic        yn0_ff, yn1_ff;

   // Stage 1: coarse normalisation by 16 and 8.
   logic [31:0] ax1_in, ay1_in, m1;
   always_comb begin
      ax1_in = ax0_ff;
      ay1_in = ay0_ff;
      m1 = (ax1_in > ay1_in) ? ax1_in : ay1_in;
      if (m1[31:16] == 16'd0) begin
         ax1_in = ax1_in << 16; ay1_in = ay1_in << 16; m1 = m1 << 16;
      end
      if (m1[31:24] == 8'd0) begin
         ax1_in = ax1_in << 8; ay1_in = ay1_in << 8; m1 = m1 << 8;
      end
   end

   // Stage 2: fine normalisation by 4, 2 and 1, then the signed vector.
   logic [31:0] ax2, ay2, m2;
   logic signed [VecWidth-1:0] x2_in, y2_in, x2_ff, y2_ff;
   always_comb begin
      ax2 = ax1_ff;
      ay2 = ay1_ff;
      m2  = (ax2 > ay2) ? ax2 : ay2;
      if (m2[31:28] == 4'd0) begin
         ax2 = ax2 << 4; ay2 = ay2 << 4; m2 = m2 << 4;
      end
      if (m2[31:30] == 2'd0) begin
         ax2 = ax2 << 2; ay2 = ay2 << 2; m2 = m2 << 2;
      end
      if (!m2[31]) begin
         ax2 = ax2 << 1; ay2 = ay2 << 1;
      end
      x2_in = $signed({4'b0, ax2});
      y2_in = yn1_ff ? -$signed({4'b0, ay2}) : $signed({4'b0, ay2});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid; v1_ff <= v0_ff; v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in; ax0_ff <= ax0_in; ay0_ff <= ay0_in; yn0_ff <= yn0_in;
         s1_ff <= s0_ff; ax1_ff <= ax1_in; ay1_ff <= ay1_in; yn1_ff <= yn0_ff;
         s2_ff <= s1_ff; x2_ff <= x2_in; y2_ff <= y2_in;
      end
   end

   logic                       vc;
   logic signed [RotWidth-1:0] rc_x, rc_y;
   side_type                   sc;

   habc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v2_ff),
      .in_x     (x2_ff),
      .in_y     (y2_ff),
      .in_side  (s2_ff),
      .out_valid(vc),
      .out_x    (rc_x),
      .out_y    (rc_y),
      .out_side (sc)
   );

   // Trig stage: undo the fold, round to FRAC_BITS, zero velocity override.
   logic signed [RotWidth-1:0] tx, ty, txr, tyr;
   logic signed [TW-1:0] c_in, s_in, c_ff, s_ff;
   always_comb begin
      tx  = sc.flip ? -rc_x : rc_x;
      ty  = sc.flip ? -rc_y : rc_y;
      txr = (tx + RHALF) >>> RS;
      tyr = (ty + RHALF) >>> RS;
      if (sc.zero) begin
         c_in = ONE;
         s_in = '0;
      end else begin
         c_in = txr[TW-1:0];
         s_in = tyr[TW-1:0];
      end
   end

   logic     vt_ff, vm_ff, vr_ff, vs_ff;
   side_type st_ff, sm_ff, sr_ff;

   // Multiply stage: eight products.
   logic signed [PW-1:0] p_ff [8];
   logic signed [SW-1:0] q_ff [8];
   logic signed [SW-1:0] q_in [8];
   logic signed [PW-1:0] pr   [8];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pr[i]   = (p_ff[i] + PHALF) >>> FRAC_BITS;
         q_in[i] = pr[i][SW-1:0];
      end
   end

   // Corner sums, products in order er*c, er*s, el*s, el*c, eg*s, eg*c, ef*c, ef*s.
   logic signed [SW-1:0] k_in [8];
   logic signed [31:0]   k_ff [8];
   logic signed [SW-1:0] cxw, cyw;
   always_comb begin
      cxw = SW'(sr_ff.cx);
      cyw = SW'(sr_ff.cy);
      k_in[0] = cxw + q_ff[0] - q_ff[2];
      k_in[1] = cyw + q_ff[1] + q_ff[3];
      k_in[2] = cxw + q_ff[0] + q_ff[4];
      k_in[3] = cyw + q_ff[1] - q_ff[5];
      k_in[4] = cxw - q_ff[6] + q_ff[4];
      k_in[5] = cyw - q_ff[7] - q_ff[5];
      k_in[6] = cxw - q_ff[6] - q_ff[2];
      k_in[7] = cyw - q_ff[7] + q_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0; vm_ff <= 1'b0; vr_ff <= 1'b0; vs_ff <= 1'b0;
      end else if (adv) begin
         vt_ff <= vc; vm_ff <= vt_ff; vr_ff <= vm_ff; vs_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= sc;
         c_ff  <= c_in;
         s_ff  <= s_in;
         sm_ff <= st_ff;
         p_ff[0] <= PW'(st_ff.er * c_ff);
         p_ff[1] <= PW'(st_ff.er * s_ff);
         p_ff[2] <= PW'(st_ff.el * s_ff);
         p_ff[3] <= PW'(st_ff.el * c_ff);
         p_ff[4] <= PW'(st_ff.eg * s_ff);
         p_ff[5] <= PW'(st_ff.eg * c_ff);
         p_ff[6] <= PW'(st_ff.ef * c_ff);
         p_ff[7] <= PW'(st_ff.ef * s_ff);
         sr_ff <= sm_ff;
         for (int i = 0; i < 8; i++) begin
            q_ff[i] <= q_in[i];
            k_ff[i] <= sat32(k_in[i]);
         end
      end
   end

   // Output register: holds four corners and sends them one word a cycle while rsp_tready is high.
   logic              busy_ff;
   logic [1:0]        cnt_ff;
   logic signed [31:0] o_ff [8];
   logic              take, rsp_fire;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign take       = !busy_ff || (rsp_fire && cnt_ff == 2'd3);
   assign adv        = !vs_ff || take;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else if (vs_ff && take) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 2'd0;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (vs_ff && take) begin
         for (int i = 0; i < 8; i++) o_ff[i] <= k_ff[i];
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = cnt_ff;
   assign rsp_tlast  = (cnt_ff == 2'd3);
   assign rsp_tdata  = {o_ff[{cnt_ff, 1'b1}], o_ff[{cnt_ff, 1'b0}]};

endmodule
`default_nettype wire

>>> rtl/habc_checker.sv
// ----------------------------------------------------------------------------
// habc_checker
// Port-level checks on the response stream of the box corner core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heading_aligned_box_corners_core_macros.svh"
module habc_checker (
   input wire        clock,
   input wire        reset,
   input wire [63:0] rsp_tdata,
   input wire [1:0]  rsp_tuser,
   input wire        rsp_tlast,
   input wire        rsp_tvalid,
   input wire        rsp_tready
);
   // A stalled word holds its contents.
   `HABC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response word changed while stalled")

   // Only the fourth corner closes the run.
   `HABC_ASSERT_NOW(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == 2'd3), "tlast does not match corner index")

   // The corners of a run follow one another without a gap.
   `HABC_ASSERT_NEXT(a_run_seq, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1, "corner run broken")

endmodule

bind heading_aligned_box_corners_core habc_checker u_habc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);
`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Heading-aligned box corner core testbench
// Drives circular obstacles into the core and checks each corner word against
// a CORDIC-based predictor of cosine and sine of the heading. It starts with a
// directed table, then runs random words under several extent settings, with
// random gaps on both streams and one long stall on the corner stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import habc_pkg::*;

   localparam int Steps = 16;
   localparam int Frac = 16;
   localparam int PhaseItems = 70;
   localparam int IdleLimit = 6000;
   localparam int SettleCycles = Steps + 16;
   localparam int LongHoldAt = 400;
   localparam logic [7:0] RegUnknown = 8'hFF;
   localparam longint S32Max = 64'sd2147483647;
   localparam longint S32Min = -64'sd2147483648;

   typedef struct {
      logic [1:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic        last;
   } corner_type;

   typedef struct {
      logic [31:0] cx, cy, vx, vy;
      logic [30:0] radius;
      bit          typed;
      logic [31:0] ex[4];
      logic [31:0] ey[4];
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [159:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast, rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   corner_type corners_due[$];
   logic signed [31:0] extent[CfgCount];
   int errors = 0;
   int idle_cycles = 0;
   int corners_seen = 0;

   always #6 clock = ~clock;

   heading_aligned_box_corners_core #(.CORDIC_STEPS(Steps), .FRAC_BITS(Frac)) u_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint clamp32(input longint v);
      if (v > S32Max) return S32Max;
      if (v < S32Min) return S32Min;
      return v;
   endfunction

   function automatic longint round_shift(input longint v, input int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   // Vectoring records the rotation directions, rotating 1/K replays them.
   task automatic heading_cos_sin(input longint vx, input longint vy,
                                  output longint c, output longint s);
      bit dir[Steps];
      bit flip;
      longint x, y, nx, ny, ax, ay, m;
      int k;
      flip = 0;
      k = 0;
      if (vx == 0 && vy == 0) begin
         c = 64'sd1 <<< Frac;
         s = 0;
         return;
      end
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         flip = 1;
      end
      ax = vx;
      ay = (vy < 0) ? -vy : vy;
      m = (ax > ay) ? ax : ay;
      while (m < 64'sh80000000) begin
         m = m <<< 1;
         k++;
      end
      x = ax <<< k;
      y = (vy < 0) ? -(ay <<< k) : (ay <<< k);
      for (int i = 0; i < Steps; i++) begin
         dir[i] = (y >= 0);
         if (dir[i]) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
         end
         x = nx;
         y = ny;
      end
      x = longint'(InvGain);
      y = 0;
      for (int i = 0; i < Steps; i++) begin
         if (dir[i]) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
         end
         x = nx;
         y = ny;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = round_shift(x, TrigFrac - Frac);
      s = round_shift(y, TrigFrac - Frac);
   endtask

   task automatic predict_corners(input row_type r);
      longint cx, cy, c, s, ef, er, eg, el;
      longint px[4], py[4];
      corner_type w;
      cx = longint'(signed'(r.cx));
      cy = longint'(signed'(r.cy));
      ef = clamp32(longint'(r.radius) + extent[REG_FRONT]);
      er = clamp32(longint'(r.radius) + extent[REG_REAR]);
      eg = clamp32(longint'(r.radius) + extent[REG_RIGHT]);
      el = clamp32(longint'(r.radius) + extent[REG_LEFT]);
      heading_cos_sin(longint'(signed'(r.vx)), longint'(signed'(r.vy)), c, s);
      px[0] = cx + round_shift(er * c, Frac) - round_shift(el * s, Frac);
      py[0] = cy + round_shift(er * s, Frac) + round_shift(el * c, Frac);
      px[1] = cx + round_shift(er * c, Frac) + round_shift(eg * s, Frac);
      py[1] = cy + round_shift(er * s, Frac) - round_shift(eg * c, Frac);
      px[2] = cx - round_shift(ef * c, Frac) + round_shift(eg * s, Frac);
      py[2] = cy - round_shift(ef * s, Frac) - round_shift(eg * c, Frac);
      px[3] = cx - round_shift(ef * c, Frac) - round_shift(el * s, Frac);
      py[3] = cy - round_shift(ef * s, Frac) + round_shift(el * c, Frac);
      for (int k = 0; k < 4; k++) begin
         w.index = k[1:0];
         w.x = r.typed ? r.ex[k] : 32'(clamp32(px[k]));
         w.y = r.typed ? r.ey[k] : 32'(clamp32(py[k]));
         w.last = (k == 3);
         corners_due = {corners_due, w};
      end
   endtask

   // Valid stays high across back-to-back words; it is only lowered for a gap.
   task automatic send_obstacle(input row_type r);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 9) == 0) ?
            $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, r.radius, r.vy, r.vx, r.cy, r.cx};
      predict_corners(r);
      do @(posedge clock); while (!req_tready);
   endtask

   // The valid line drops for one cycle after each write.
   task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index < CfgCount) extent[index[1:0]] = value;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (corners_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_velocity();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return $urandom_range(0, 8) - 4;
         4: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic row_type rand_row();
      row_type r;
      r.typed = 0;
      r.cx = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h1FFFFFF) - 32'hFFFFFF;
      r.cy = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h1FFFFFF) - 32'hFFFFFF;
      r.vx = rand_velocity();
      r.vy = rand_velocity();
      r.radius = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'hFFFFF));
      return r;
   endfunction

   function automatic logic [31:0] rand_extent();
      return ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
   endfunction

   // Corner side: random stalls, plus one long hold so the pipeline backs up.
   initial begin : corner_sink
      bit ready;
      bit long_done;
      corner_type want;
      int hold;
      hold = 0;
      long_done = 0;
      forever begin
         if (hold > 0) begin
            ready = 0;
            hold--;
         end else if (corners_seen == LongHoldAt && !long_done) begin
            ready = 0;
            long_done = 1;
            hold = 300;
         end else begin
            ready = ($urandom_range(0, 5) != 0);
         end
         rsp_tready <= ready;
         @(posedge clock);
         if (ready && rsp_tvalid && !reset) begin
            corners_seen++;
            if (corners_due.size() == 0) begin
               $display("%0t: corner word with nothing expected: idx %0d x %h y %h",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
               errors++;
            end else begin
               want = corners_due.pop_front();
               if (rsp_tuser !== want.index || rsp_tdata[31:0] !== want.x ||
                   rsp_tdata[63:32] !== want.y || rsp_tlast !== want.last) begin
                  $display("%0t: corner mismatch: expected idx %0d x %h y %h last %b,",
                           $time, want.index, want.x, want.y, want.last);
                  $display("%0t:   actual idx %0d x %h y %h last %b", $time,
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IdleLimit);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      row_type rows[$];
      row_type r;
      for (int i = 0; i < CfgCount; i++) extent[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extents are zero here, so zero-velocity rows are centre plus or minus radius.
      r = '{cx: 0, cy: 0, vx: 0, vy: 0, radius: 0, typed: 1,
            ex: '{0, 0, 0, 0}, ey: '{0, 0, 0, 0}};
      rows = {rows, r};
      r = '{cx: 32'h00050000, cy: 32'hFFF90000, vx: 0, vy: 0, radius: 31'h00030000, typed: 1,
            ex: '{32'h00080000, 32'h00080000, 32'h00020000, 32'h00020000},
            ey: '{32'hFFFC0000, 32'hFFF60000, 32'hFFF60000, 32'hFFFC0000}};
      rows = {rows, r};
      r = '{cx: 32'h7FFFFFFF, cy: 32'h80000000, vx: 0, vy: 0, radius: 31'h7FFFFFFF, typed: 1,
            ex: '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0},
            ey: '{32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'hFFFFFFFF}};
      rows = {rows, r};
      r.typed = 0;
      r.cx = 32'h00100000;
      r.cy = 32'hFFF00000;
      r.radius = 31'h00020000;
      begin
         logic [31:0] vxs[14];
         logic [31:0] vys[14];
         vxs = '{32'h1, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF,
            32'h80000000, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h3,
            32'hFFFFFFFB, 32'h7FFFFFFF, 32'h00010000};
         vys = '{32'h0, 32'h1, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 32'h0, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h4,
            32'h2, 32'h80000000, 32'h00010000};
         for (int i = 0; i < 14; i++) begin
            r.vx = vxs[i];
            r.vy = vys[i];
            r.radius = (i == 13) ? 31'h7FFFFFFF : 31'(i << 16);
            rows = {rows, r};
         end
      end
      foreach (rows[i]) send_obstacle(rows[i]);
      wait_idle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: for (int i = 0; i < CfgCount; i++) write_reg(8'(i), 32'h7FFFFFFF);
            2: for (int i = 0; i < CfgCount; i++) write_reg(8'(i), 32'h80000000);
            3: begin
               write_reg(8'(REG_FRONT), 32'h80000000);
               write_reg(8'(REG_REAR), 32'h7FFFFFFF);
               write_reg(8'(REG_RIGHT), 32'h0);
               write_reg(8'(REG_LEFT), 32'hFFFF0000);
               write_reg(RegUnknown, 32'h12345678);
               write_reg(8'h04, 32'hFFFFFFFF);
            end
            default: for (int i = 0; i < CfgCount; i++) write_reg(8'(i), rand_extent());
         endcase
         for (int n = 0; n < PhaseItems; n++) send_obstacle(rand_row());
         wait_idle();
      end

      repeat (SettleCycles) @(posedge clock);
      if (errors == 0 && corners_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
